// ----- hdl/ffha_pkg.sv -----
`default_nettype none
package ffha_pkg;
  localparam int unsigned HeapGranulesDefault = 4096;
  localparam int unsigned HeapBaseDefault = 0;

  typedef enum logic [1:0] {
    STATUS_OK = 2'd0,
    STATUS_OOM = 2'd1,
    STATUS_DOUBLE_FREE = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE = 1'b1
  } op_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_RD,
    ST_A_CHK,
    ST_A_WPAD,
    ST_A_WPADPREV,
    ST_A_WTAIL,
    ST_A_WTAILN,
    ST_A_WH,
    ST_A_WNEXTP,
    ST_F_RD,
    ST_F_CHK,
    ST_F_NRD,
    ST_F_NCHK,
    ST_F_PRD,
    ST_F_PCHK,
    ST_F_P2RD,
    ST_F_P2CHK,
    ST_DONE
  } state_t;
endpackage
`default_nettype wire

// ----- hdl/ffha_hdr_mem.sv -----
`default_nettype none
module ffha_hdr_mem #(
  parameter int unsigned AW = 12,
  parameter int unsigned DW = 26
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [AW-1:0] waddr,
  input wire logic [DW-1:0] wdata,
  input wire logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hdl/first_fit_heap_allocator.sv -----
`default_nettype none
// channel  | ports                                         | dir
// command  | start, busy, op, request_bytes, alignment,    | in
//          |   release_address                             |
// result   | done, block_address, status                   | out
//
// Header RAM is simple dual port: one read and one write a cycle, read data
// in the cycle after the address. An allocate reads and checks each block
// walked, then does the split writes and finish; a free checks the block,
// merges free neighbours, then finishes. After reset a clearing pass writes
// all HEAP_GRANULES headers, one per cycle, while busy stays high.
// The result word is shown for one cycle with done; it cannot be stalled.
module first_fit_heap_allocator #(
  parameter int unsigned HEAP_GRANULES = ffha_pkg::HeapGranulesDefault,
  parameter int unsigned HEAP_BASE = ffha_pkg::HeapBaseDefault
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  output logic busy,
  input wire logic op,
  input wire logic [15:0] request_bytes,
  input wire logic [15:0] alignment,
  input wire logic [14:0] release_address,
  output logic done,
  output logic [14:0] block_address,
  output logic [1:0] status
);
  import ffha_pkg::*;

  // header: {live, free, prev, next}
  localparam int unsigned GW = $clog2(HEAP_GRANULES);
  localparam int unsigned DW = 2 * GW + 2;
  // byte address width: heap size with overflow room, and a rounded 64 KiB size
  localparam int unsigned BW = (GW + 4 > 17) ? GW + 4 : 17;
  localparam logic [GW-1:0] Sentinel = GW'(HEAP_GRANULES - 1);

  typedef struct packed {
    logic live;
    logic fr;
    logic [GW-1:0] prev;
    logic [GW-1:0] next;
  } hdr_t;

  state_t state, state_next;
  logic we;
  logic [GW-1:0] waddr, raddr;
  hdr_t wdata, rd;
  logic [DW-1:0] rdata;

  // per-item registers
  logic [GW-1:0] cur, cur_next;      // block under inspection
  logic [GW-1:0] nxt, nxt_next;      // its next
  logic [GW-1:0] hg, hg_next;        // allocated header / freed block
  logic [GW-1:0] tg, tg_next;        // tail header
  logic [GW-1:0] pg, pg_next;        // previous block
  logic has_pad, has_pad_next, has_tail, has_tail_next;
  logic [BW-1:0] size_b, size_b_next;
  logic [BW-1:0] amask, amask_next;  // align - 1
  logic [GW:0] steps, steps_next;
  logic [14:0] addr_q, addr_next;
  logic [1:0] st_q, st_next;
  hdr_t cur_h, cur_h_next;
  logic done_next;

  ffha_hdr_mem #(.AW(GW), .DW(DW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );
  assign rd = hdr_t'(rdata);

  // alignment rounded to a power of two, at least 8, as a mask
  logic [16:0] al_m1;
  logic [16:0] al_pow;
  always_comb begin
    al_m1 = {1'b0, alignment} - 17'd1;
    al_m1 = al_m1 | (al_m1 >> 1);
    al_m1 = al_m1 | (al_m1 >> 2);
    al_m1 = al_m1 | (al_m1 >> 4);
    al_m1 = al_m1 | (al_m1 >> 8);
    al_pow = al_m1 | 17'd7;
    if (alignment == 16'd0) al_pow = 17'd7;
  end

  // fit check on the current block
  logic [BW+1:0] baddr, aligned, fend, nend;
  always_comb begin
    baddr = (BW+2)'({cur, 3'b000}) + (BW+2)'(8);
    aligned = (baddr + (BW+2)'(amask)) & ~(BW+2)'(amask);
    fend = aligned + (BW+2)'(size_b);
    nend = (BW+2)'({rd.next, 3'b000});
  end

  // free address decode
  logic [14:0] rel_off;
  logic [GW-1:0] fg;
  logic f_bad;
  always_comb begin
    rel_off = release_address - 15'(HEAP_BASE);
    fg = GW'((rel_off >> 3) - 15'd1);
    f_bad = (32'(release_address) < HEAP_BASE + 8) || (rel_off[2:0] != 3'd0) ||
            (32'(rel_off >> 3) >= HEAP_GRANULES);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      done <= 1'b0;
      cur <= '0;
    end else begin
      state <= state_next;
      done <= done_next;
      cur <= cur_next;
    end
    nxt <= nxt_next; hg <= hg_next; tg <= tg_next; pg <= pg_next;
    has_pad <= has_pad_next; has_tail <= has_tail_next;
    size_b <= size_b_next; amask <= amask_next; steps <= steps_next;
    addr_q <= addr_next; st_q <= st_next; cur_h <= cur_h_next;
  end

  assign busy = (state != ST_IDLE);
  assign block_address = addr_q;
  assign status = st_q;

  always_comb begin
    state_next = state;
    cur_next = cur; nxt_next = nxt; hg_next = hg; tg_next = tg; pg_next = pg;
    has_pad_next = has_pad; has_tail_next = has_tail;
    size_b_next = size_b; amask_next = amask; steps_next = steps;
    addr_next = addr_q; st_next = st_q; cur_h_next = cur_h;
    done_next = 1'b0;
    we = 1'b0; waddr = cur; wdata = '0; raddr = cur;
    unique case (state)
      ST_CLEAR: begin
        // sweep: block 0 free to sentinel, sentinel live, rest cleared
        we = 1'b1;
        waddr = cur;
        if (cur == '0) wdata = '{live: 1'b1, fr: 1'b1, prev: '0, next: Sentinel};
        else if (cur == Sentinel) wdata = '{live: 1'b1, fr: 1'b0, prev: '0, next: '0};
        cur_next = cur + 1'b1;
        if (cur == Sentinel) begin
          cur_next = '0;
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          addr_next = '0;
          st_next = STATUS_OK;
          if (op == OP_ALLOC) begin
            size_b_next = BW'(({1'b0, request_bytes} + 17'd7) & ~17'd7);
            amask_next = BW'(al_pow);
            cur_next = '0;
            steps_next = '0;
            state_next = ST_A_RD;
          end else if (release_address == 15'd0) begin
            state_next = ST_DONE;
          end else if (f_bad) begin
            st_next = STATUS_DOUBLE_FREE;
            state_next = ST_DONE;
          end else begin
            hg_next = fg;
            state_next = ST_F_RD;
          end
        end
      end
      ST_A_RD: begin
        raddr = cur;
        if (cur >= Sentinel || steps == (GW+1)'(HEAP_GRANULES)) begin
          st_next = STATUS_OOM;
          state_next = ST_DONE;
        end else begin
          state_next = ST_A_CHK;
        end
      end
      ST_A_CHK: begin
        cur_h_next = rd;
        nxt_next = rd.next;
        steps_next = steps + 1'b1;
        if (rd.fr && fend <= nend) begin
          has_pad_next = (aligned != baddr);
          hg_next = has_pad_next ? GW'((aligned >> 3) - 1'b1) : cur;
          has_tail_next = (nend - fend) > (BW+2)'(8);
          tg_next = GW'(fend >> 3);
          addr_next = 15'((BW+2)'(HEAP_BASE) + aligned);
          state_next = has_pad_next ? ST_A_WPAD : ST_A_WH;
        end else begin
          cur_next = rd.next;
          state_next = ST_A_RD;
        end
      end
      ST_A_WPAD: begin
        // front pad keeps the old header, now ending at the new block
        we = 1'b1; waddr = cur;
        wdata = cur_h; wdata.next = hg;
        state_next = ST_A_WH;
      end
      ST_A_WH: begin
        we = 1'b1; waddr = hg;
        wdata = '{live: 1'b1, fr: 1'b0,
                  prev: has_pad ? cur : cur_h.prev,
                  next: has_tail ? tg : nxt};
        state_next = has_tail ? ST_A_WTAIL : ST_A_WNEXTP;
      end
      ST_A_WTAIL: begin
        we = 1'b1; waddr = tg;
        wdata = '{live: 1'b1, fr: 1'b1, prev: hg, next: nxt};
        state_next = ST_A_WNEXTP;
      end
      ST_A_WNEXTP: begin
        // fix prev of the following block; read it first
        raddr = nxt;
        state_next = ST_A_WTAILN;
      end
      ST_A_WTAILN: begin
        we = 1'b1; waddr = nxt;
        wdata = rd; wdata.prev = has_tail ? tg : hg;
        st_next = STATUS_OK;
        state_next = ST_DONE;
      end
      ST_F_RD: begin
        raddr = hg;
        state_next = ST_F_CHK;
      end
      ST_F_CHK: begin
        if (!rd.live || rd.fr) begin
          st_next = STATUS_DOUBLE_FREE;
          state_next = ST_DONE;
        end else begin
          cur_h_next = rd; cur_h_next.fr = 1'b1;
          nxt_next = rd.next;
          pg_next = rd.prev;
          state_next = ST_F_NRD;
        end
      end
      ST_F_NRD: begin
        raddr = nxt;
        state_next = ST_F_NCHK;
      end
      ST_F_NCHK: begin
        // merge forward: absorb free next block
        if (nxt < Sentinel && rd.fr) begin
          cur_h_next.next = rd.next;
          nxt_next = rd.next;
          we = 1'b1; waddr = nxt;
          wdata = rd; wdata.live = 1'b0;
          state_next = ST_F_PRD;
        end else begin
          state_next = ST_F_PRD;
        end
      end
      ST_F_PRD: begin
        // write freed header and fix prev of the block after it
        we = 1'b1; waddr = hg; wdata = cur_h;
        raddr = nxt;
        state_next = ST_F_PCHK;
      end
      ST_F_PCHK: begin
        we = 1'b1; waddr = nxt; wdata = rd; wdata.prev = hg;
        raddr = pg;
        if (hg != '0 && pg < hg) state_next = ST_F_P2RD;
        else state_next = ST_DONE;
      end
      ST_F_P2RD: begin
        // rd holds previous header (read issued last cycle)
        if (rd.fr) begin
          cur_h_next = rd;
          cur_h_next.next = cur_h.next;
          we = 1'b1; waddr = pg; wdata = cur_h_next;
          state_next = ST_F_P2CHK;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_F_P2CHK: begin
        // drop the freed header; next block now links back to prev
        we = 1'b1; waddr = hg; wdata = '0;
        raddr = nxt;
        state_next = ST_A_WTAILN;
        has_tail_next = 1'b0;
        hg_next = pg;
        addr_next = '0;
      end
      ST_DONE: begin
        done_next = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // the result word appears only in idle, on the cycle after the done state
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == ST_IDLE)
    else $error("result outside idle");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result longer than one cycle");
  a_oom_addr: assert property (@(posedge clk) disable iff (rst)
    done && status == STATUS_OOM |-> block_address == 15'd0)
    else $error("address on failed allocate");
endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
`default_nettype none
module tb_top;
  import ffha_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Granules = 4096;
  localparam int unsigned Sentinel = Granules - 1;
  localparam int unsigned IdleLimit = 200000;

  // one command word as the driver sees it
  typedef struct packed {
    op_t op;
    logic [15:0] request_bytes;
    logic [15:0] alignment;
    logic [14:0] release_address;
  } cmd_t;

  typedef struct packed {
    logic [14:0] block_address;
    status_t status;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic op = 1'b0;
  logic [15:0] request_bytes = '0;
  logic [15:0] alignment = '0;
  logic [14:0] release_address = '0;
  logic busy, done;
  logic [14:0] block_address;
  logic [1:0] status;

  first_fit_heap_allocator i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .request_bytes(request_bytes), .alignment(alignment),
    .release_address(release_address), .done(done),
    .block_address(block_address), .status(status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow heap: one header per granule
  logic [11:0] hdr_next [Granules];
  logic [11:0] hdr_prev [Granules];
  bit hdr_free [Granules];
  bit hdr_live [Granules];

  cmd_t pending_cmds[$];
  reply_t expected_replies[$];
  int unsigned live_payloads[$];   // addresses handed out, for realistic frees
  int unsigned errors = 0;

  function automatic void heap_reset();
    for (int i = 0; i < Granules; i++) begin
      hdr_next[i] = '0;
      hdr_prev[i] = '0;
      hdr_free[i] = 0;
      hdr_live[i] = 0;
    end
    hdr_live[0] = 1;
    hdr_free[0] = 1;
    hdr_next[0] = 12'(Sentinel);
    hdr_live[Sentinel] = 1;
  endfunction

  function automatic void chain(int unsigned from, int unsigned to);
    hdr_next[from] = 12'(to);
    hdr_prev[to] = 12'(from);
  endfunction

  function automatic void absorb_next(int unsigned g);
    int unsigned n;
    n = hdr_next[g];
    if (n >= Sentinel || !hdr_free[n]) return;
    chain(g, hdr_next[n]);
    hdr_live[n] = 0;
  endfunction

  // first-fit walk; padding block in front, tail split when > one granule left
  function automatic reply_t predict_alloc(int unsigned size_in, int unsigned align_in);
    int unsigned align, size, hb, steps, nxt, addr, aligned, end_b, h, s;
    reply_t r;
    align = 8;
    size = (size_in + 7) & ~32'd7;
    hb = 0;
    steps = 0;
    while (align < align_in) align = align << 1;
    while (hb < Sentinel && steps < Granules) begin
      nxt = hdr_next[hb];
      steps++;
      if (hdr_free[hb]) begin
        addr = (hb + 1) * 8;
        aligned = (addr + align - 1) & ~(align - 1);
        end_b = aligned + size;
        if (end_b <= nxt * 8) begin
          h = hb;
          if (aligned != addr) begin
            h = aligned / 8 - 1;
            hdr_live[h] = 1;
            chain(h, nxt);
            chain(hb, h);
          end
          hdr_free[h] = 0;
          if (nxt * 8 - end_b > 8) begin
            s = end_b / 8;
            hdr_live[s] = 1;
            hdr_free[s] = 1;
            chain(s, nxt);
            chain(h, s);
          end
          r.block_address = 15'(aligned);
          r.status = STATUS_OK;
          return r;
        end
      end
      hb = nxt;
    end
    r.block_address = '0;
    r.status = STATUS_OOM;
    return r;
  endfunction

  function automatic reply_t heap_release(int unsigned addr);
    int unsigned g, p;
    reply_t r;
    r.block_address = '0;
    r.status = STATUS_OK;
    if (addr == 0) return r;
    r.status = STATUS_DOUBLE_FREE;
    if (addr < 8 || (addr & 7) != 0) return r;
    g = addr / 8 - 1;
    if (g >= Sentinel || !hdr_live[g] || hdr_free[g]) return r;
    r.status = STATUS_OK;
    hdr_free[g] = 1;
    absorb_next(g);
    if (g != 0) begin
      p = hdr_prev[g];
      if (p < g && hdr_free[p]) absorb_next(p);
    end
    return r;
  endfunction

  function automatic cmd_t mk_alloc(int unsigned sz, int unsigned al);
    cmd_t c;
    c.op = OP_ALLOC;
    c.request_bytes = 16'(sz);
    c.alignment = 16'(al);
    c.release_address = 15'($urandom);
    return c;
  endfunction

  function automatic cmd_t mk_free(int unsigned a);
    cmd_t c;
    c.op = OP_FREE;
    c.request_bytes = 16'($urandom);
    c.alignment = 16'($urandom);
    c.release_address = 15'(a);
    return c;
  endfunction

  // mostly short gaps, now and then a long one, sometimes runs with none
  function automatic int unsigned gap_len();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) return 0;
    if (pick < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // driver: hold start until the word is taken at an edge with busy low
  int unsigned drv_gap = 0;
  bit drv_active = 0;
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (drv_active && !busy) begin
      // word accepted at this edge; predict it now
      cmd_t c;
      c = {op_t'(op), request_bytes, alignment, release_address};
      expected_replies.push_back(c.op == OP_ALLOC ?
          predict_alloc(c.request_bytes, c.alignment) : heap_release(c.release_address));
      drv_gap = gap_len();
      if (drv_gap == 0 && pending_cmds.size() > 0) begin
        c = pending_cmds.pop_front();
        {op, request_bytes, alignment, release_address} <= c;
      end else begin
        start <= 1'b0;
        drv_active = 0;
      end
    end else if (!drv_active) begin
      if (drv_gap > 0) begin
        drv_gap--;
      end else if (pending_cmds.size() > 0) begin
        cmd_t c;
        c = pending_cmds.pop_front();
        {op, request_bytes, alignment, release_address} <= c;
        start <= 1'b1;
        drv_active = 1;
      end
    end
  end

  // monitor: done marks a one-cycle result word
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_replies.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word: addr=%0d status=%0d",
                                   block_address, status);
      end else begin
        reply_t e;
        e = expected_replies.pop_front();
        if (e.block_address !== block_address || e.status !== status) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected addr=%0d status=%0d, got addr=%0d status=%0d",
                     e.block_address, e.status, block_address, status);
        end else if (e.status == STATUS_OK && e.block_address != 0) begin
          live_payloads.push_back(e.block_address);
        end
      end
    end
  end

  // watchdog on cycles with no accepted word either way
  int unsigned idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // random allocate with small sizes mostly, and a few huge ones
  function automatic cmd_t rand_alloc();
    int unsigned sz, al, pick;
    pick = $urandom_range(99);
    if (pick < 80) sz = $urandom_range(200);
    else if (pick < 95) sz = $urandom_range(2048);
    else sz = $urandom_range(65535);
    pick = $urandom_range(99);
    if (pick < 50) al = $urandom_range(8);
    else if (pick < 85) al = 1 << $urandom_range(8);
    else if (pick < 95) al = $urandom_range(300);
    else al = $urandom_range(65535);
    return mk_alloc(sz, al);
  endfunction

  initial begin
    int unsigned n, a, pick;
    heap_reset();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, alignment cases, bad frees, double free
    pending_cmds.push_back(mk_free(0));
    pending_cmds.push_back(mk_alloc(0, 0));
    pending_cmds.push_back(mk_alloc(1, 1));
    pending_cmds.push_back(mk_alloc(8, 8));
    pending_cmds.push_back(mk_alloc(9, 3));
    pending_cmds.push_back(mk_alloc(24, 64));
    pending_cmds.push_back(mk_alloc(16, 100));
    pending_cmds.push_back(mk_alloc(0, 4096));
    pending_cmds.push_back(mk_alloc(65535, 65535));
    pending_cmds.push_back(mk_alloc(32768, 32768));
    pending_cmds.push_back(mk_alloc(40, 0));
    pending_cmds.push_back(mk_free(16));
    pending_cmds.push_back(mk_free(16));          // already free
    pending_cmds.push_back(mk_free(3));           // not granule-aligned
    pending_cmds.push_back(mk_free(Sentinel * 8 + 8 - 8)); // payload just below sentinel
    pending_cmds.push_back(mk_free(32767));
    pending_cmds.push_back(mk_free(8));
    pending_cmds.push_back(mk_free(4000));        // no live header there
    pending_cmds.push_back(mk_alloc(30000, 8));
    pending_cmds.push_back(mk_alloc(16, 8));
    pending_cmds.push_back(mk_free(24));
    pending_cmds.push_back(mk_free(32));

    // random: feed in small batches so frees can target live payloads
    n = 0;
    while (n < 1050) begin
      wait (pending_cmds.size() < 4);
      @(posedge clk);
      pick = $urandom_range(99);
      if (pick < 50) begin
        pending_cmds.push_back(rand_alloc());
      end else if (pick < 85 && live_payloads.size() > 0) begin
        a = $urandom_range(live_payloads.size() - 1);
        pending_cmds.push_back(mk_free(live_payloads[a]));
        live_payloads.delete(a);
      end else if (pick < 92) begin
        pending_cmds.push_back(mk_free($urandom_range(32767)));
      end else if (pick < 96) begin
        pending_cmds.push_back(mk_free($urandom_range(4095) * 8));
      end else begin
        pending_cmds.push_back(mk_free(0));
      end
      n++;
    end

    wait (pending_cmds.size() == 0 && !drv_active);
    wait (expected_replies.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire
